/* hdl/per_view_hit_decimator_core_defines.svh */
// ----------------------------------------------------------------------------
// per_view_hit_decimator_core_defines
// Assertion macros shared by the hit decimator modules. Each macro expects
// clk_i and rst_ni to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef PER_VIEW_HIT_DECIMATOR_CORE_DEFINES_SVH
`define PER_VIEW_HIT_DECIMATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVHD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVHD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pvhd_pkg.sv */
// ----------------------------------------------------------------------------
// pvhd_pkg
// Types and constants shared by the per-view hit decimator modules.
// ----------------------------------------------------------------------------
package pvhd_pkg;

  // Default sizes of the block.
  localparam int unsigned NUM_VIEWS_DEF  = 3;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Configuration register width and the number of per-view count registers.
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned NUM_COUNT_REGS = 3;

  // Width of a view index at the largest supported number of views.
  localparam int unsigned MAX_VIEW_W = 3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAX_PER_VIEW = 2'd0,
    REG_HITS_VIEW_U  = 2'd1,
    REG_HITS_VIEW_V  = 2'd2,
    REG_HITS_VIEW_Z  = 2'd3
  } cfg_reg_e;

  // One input item.
  typedef struct packed {
    logic [1:0] hit_view;
    logic       was_enabled;
    logic       pass_start;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic now_enabled;
    logic changed_so_far;
  } out_item_t;

  // Control from the sequencer to the selection unit.
  typedef struct packed {
    logic                  clear;
    logic                  load;
    logic [MAX_VIEW_W-1:0] load_view;
    logic                  load_pol;
    logic                  step;
  } sel_ctrl_t;

endpackage

/* hdl/per_view_hit_decimator_core.sv */
// ----------------------------------------------------------------------------
// per_view_hit_decimator_core
// Thins a pass of detector hits so that each view keeps about a set number.
// ----------------------------------------------------------------------------
// Usage: write max_per_view and the three per-view hit counts through the
// configuration port (always ready) while the block is idle, then stream the
// hits of one pass on the input channel, the first one flagged pass_start.
// Each hit gives exactly one result item with its new enable bit and the
// running changed flag of the pass.
// An ordinary hit is decided in the cycle it is accepted and reaches the output
// register in the next cycle, so unless the output stalls they flow at one per cycle.
// A pass-start hit runs the ratio set-up: for each view a set-up state and,
// where a division is needed, a run of the shared restoring divider, then
// an issue state. Input is stalled throughout the set-up; the issue state
// is held for as long as a waiting result is stalled.
// Reset clears the configuration, ratios and counters, so hits are enabled.
// While out_stall_i holds a waiting result, in_stall_o is raised as well.
// ----------------------------------------------------------------------------
module per_view_hit_decimator_core #(
  parameter int unsigned NUM_VIEWS  = pvhd_pkg::NUM_VIEWS_DEF,
  parameter int unsigned COUNT_BITS = pvhd_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Hit input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pvhd_pkg::in_item_t          in_item_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pvhd_pkg::out_item_t         out_item_o,
  // Configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  pvhd_pkg::cfg_reg_e          cfg_index_i,
  input  logic [pvhd_pkg::CFG_W-1:0]  cfg_data_i
);

  import pvhd_pkg::*;

  `include "per_view_hit_decimator_core_defines.svh"

  localparam int unsigned VIEW_W = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SETUP  = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_ISSUE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [VIEW_W-1:0]     view_cnt_q, view_cnt_d;
  logic                  div_pol_q, div_pol_d;
  in_item_t              item_q;
  logic                  item_load;
  logic [CFG_W-1:0]      max_q;
  logic [CFG_W-1:0]      hits_q [NUM_COUNT_REGS];
  logic                  out_valid_q;
  out_item_t             out_item_q;

  logic                  can_issue;
  logic                  in_acc;
  logic                  last_view;
  logic [CFG_W-1:0]      n_raw;
  logic [COUNT_BITS-1:0] lim, cnt_n;
  logic                  big, above, zero_ratio;
  logic [COUNT_BITS-1:0] divisor;
  logic                  div_start, div_done;
  logic [COUNT_BITS-1:0] quotient;
  logic [COUNT_BITS-1:0] load_ratio;
  sel_ctrl_t             sel_ctrl;
  in_item_t              step_item;
  out_item_t             sel_result;

  // Configuration registers; the port is always ready. The user writes it only
  // while the block is idle; the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      for (int k = 0; k < NUM_COUNT_REGS; k++) begin
        hits_q[k] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_PER_VIEW: max_q     <= cfg_data_i;
        REG_HITS_VIEW_U:  hits_q[0] <= cfg_data_i;
        REG_HITS_VIEW_V:  hits_q[1] <= cfg_data_i;
        REG_HITS_VIEW_Z:  hits_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: items are taken only in idle and when the result slot frees.
  assign can_issue  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && can_issue);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Ratio rule for the view under set-up. Views without a count register
  // see a count of zero.
  always_comb begin
    n_raw = '0;
    for (int k = 0; k < NUM_COUNT_REGS; k++) begin
      if (int'(view_cnt_q) == k) begin
        n_raw = hits_q[k];
      end
    end
  end

  assign lim        = COUNT_BITS'(max_q);
  assign cnt_n      = COUNT_BITS'(n_raw);
  assign big        = ({1'b0, cnt_n} >= {lim, 1'b0});
  assign above      = (cnt_n > lim);
  assign zero_ratio = (lim == '0) || !above;
  assign divisor    = big ? lim : (cnt_n - lim);
  assign last_view  = (view_cnt_q == VIEW_W'(NUM_VIEWS - 1));

  // Shared divider for all views.
  pvhd_divider #(
    .WIDTH (COUNT_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cnt_n),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sequencer.
  always_comb begin
    state_d            = state_q;
    view_cnt_d         = view_cnt_q;
    div_pol_d          = div_pol_q;
    item_load          = 1'b0;
    div_start          = 1'b0;
    load_ratio         = '0;
    sel_ctrl           = '0;
    sel_ctrl.load_view = MAX_VIEW_W'(view_cnt_q);
    step_item          = item_q;
    unique case (state_q)
      S_IDLE: begin
        step_item = in_item_i;
        if (in_acc) begin
          if (in_item_i.pass_start) begin
            item_load      = 1'b1;
            sel_ctrl.clear = 1'b1;
            view_cnt_d     = '0;
            state_d        = S_SETUP;
          end else begin
            sel_ctrl.step = 1'b1;
          end
        end
      end
      S_SETUP: begin
        if (zero_ratio) begin
          sel_ctrl.load = 1'b1;
          if (last_view) begin
            state_d = S_ISSUE;
          end else begin
            view_cnt_d = view_cnt_q + VIEW_W'(1);
          end
        end else begin
          div_start = 1'b1;
          div_pol_d = big;
          state_d   = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          sel_ctrl.load     = 1'b1;
          sel_ctrl.load_pol = div_pol_q;
          load_ratio        = quotient;
          if (last_view) begin
            state_d = S_ISSUE;
          end else begin
            view_cnt_d = view_cnt_q + VIEW_W'(1);
            state_d    = S_SETUP;
          end
        end
      end
      S_ISSUE: begin
        if (can_issue) begin
          sel_ctrl.step = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      view_cnt_q <= '0;
      div_pol_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      view_cnt_q <= view_cnt_d;
      div_pol_q  <= div_pol_d;
    end
  end

  // Holds a pass-start item while its ratios are worked out.
  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= in_item_i;
    end
  end

  // Per-view selection state.
  pvhd_select #(
    .NUM_VIEWS  (NUM_VIEWS),
    .COUNT_BITS (COUNT_BITS)
  ) u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sel_ctrl),
    .load_ratio_i (load_ratio),
    .hit_i        (step_item),
    .result_o     (sel_result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sel_ctrl.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_ctrl.step) begin
      out_item_q <= sel_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PVHD_ASSERT_IMP(a_acc_idle, in_acc, state_q == S_IDLE, "item accepted outside idle")
  `PVHD_ASSERT_IMP(a_div_setup, div_start, state_q == S_SETUP, "divider started outside set-up")
  `PVHD_ASSERT_IMP(a_done_divide, div_done, state_q == S_DIVIDE, "divider done outside divide")
  `PVHD_ASSERT_IMP(a_no_overwrite, sel_ctrl.step, can_issue, "waiting result overwritten")

endmodule

/* hdl/pvhd_divider.sv */
// ----------------------------------------------------------------------------
// pvhd_divider
// Restoring unsigned divider, one quotient bit per cycle. Shared by all views
// to derive the decimation ratios at the start of a pass.
// ----------------------------------------------------------------------------
module pvhd_divider #(
  parameter int unsigned WIDTH = pvhd_pkg::COUNT_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);

  `include "per_view_hit_decimator_core_defines.svh"

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  logic             running_q, running_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, quo_q, div_q;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  // Step counter and completion flag.
  always_comb begin
    running_d = running_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = CNT_W'(WIDTH);
    end else if (running_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  // Datapath: the dividend register shifts out its top bit and takes in the
  // quotient bits from below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (running_q) begin
      rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      quo_q <= {quo_q[WIDTH-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `PVHD_ASSERT_IMP(a_start_idle, start_i, !running_q, "divider started while busy")
  `PVHD_ASSERT_IMP(a_done_stopped, done_q, !running_q, "divider done while still running")
  `PVHD_ASSERT_NXT(a_start_runs, start_i, running_q, "divider did not start")

endmodule

/* hdl/pvhd_select.sv */
// ----------------------------------------------------------------------------
// pvhd_select
// Per-view ratio, polarity and position registers, and the enable decision
// for one hit together with the running changed flag.
// ----------------------------------------------------------------------------
module pvhd_select #(
  parameter int unsigned NUM_VIEWS  = pvhd_pkg::NUM_VIEWS_DEF,
  parameter int unsigned COUNT_BITS = pvhd_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvhd_pkg::sel_ctrl_t  ctrl_i,
  input  logic [COUNT_BITS-1:0] load_ratio_i,
  input  pvhd_pkg::in_item_t   hit_i,
  output pvhd_pkg::out_item_t  result_o
);

  import pvhd_pkg::*;

  logic [COUNT_BITS-1:0] ratio_q [NUM_VIEWS];
  logic [COUNT_BITS-1:0] ratio_d [NUM_VIEWS];
  logic [COUNT_BITS-1:0] pos_q   [NUM_VIEWS];
  logic [COUNT_BITS-1:0] pos_d   [NUM_VIEWS];
  logic [COUNT_BITS:0]   pos_inc [NUM_VIEWS];
  logic [NUM_VIEWS-1:0]  pol_q, pol_d;
  logic [NUM_VIEWS-1:0]  hit_here;
  logic [NUM_VIEWS-1:0]  load_here;
  logic                  changed_q, changed_d;
  logic                  now_en;

  // View decode for the hit and for the ratio load.
  always_comb begin
    for (int v = 0; v < NUM_VIEWS; v++) begin
      hit_here[v]  = (int'(hit_i.hit_view) == v);
      load_here[v] = ctrl_i.load && (int'(ctrl_i.load_view) == v);
      pos_inc[v]   = {1'b0, pos_q[v]} + (COUNT_BITS + 1)'(1);
    end
  end

  // Enable decision: position zero takes the polarity, the rest its inverse; a view with ratio zero keeps hits enabled.
  always_comb begin
    now_en = 1'b1;
    for (int v = 0; v < NUM_VIEWS; v++) begin
      if (hit_here[v] && (ratio_q[v] != '0)) begin
        now_en = (pos_q[v] == '0) ? pol_q[v] : ~pol_q[v];
      end
    end
  end

  // Next state of the per-view registers and the changed flag.
  always_comb begin
    changed_d = changed_q;
    pol_d     = pol_q;
    for (int v = 0; v < NUM_VIEWS; v++) begin
      ratio_d[v] = ratio_q[v];
      pos_d[v]   = pos_q[v];
      if (ctrl_i.clear) begin
        pos_d[v] = '0;
      end
      if (load_here[v]) begin
        ratio_d[v] = load_ratio_i;
        pol_d[v]   = ctrl_i.load_pol;
        pos_d[v]   = '0;
      end
      if (ctrl_i.step && hit_here[v] && (ratio_q[v] != '0)) begin
        if (pos_inc[v] >= {1'b0, ratio_q[v]}) begin
          pos_d[v] = '0;
        end else begin
          pos_d[v] = pos_inc[v][COUNT_BITS-1:0];
        end
      end
    end
    if (ctrl_i.clear) begin
      changed_d = 1'b0;
    end
    if (ctrl_i.step && (now_en != hit_i.was_enabled)) begin
      changed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_VIEWS; v++) begin
        ratio_q[v] <= '0;
        pos_q[v]   <= '0;
      end
      pol_q     <= '0;
      changed_q <= 1'b0;
    end else begin
      for (int v = 0; v < NUM_VIEWS; v++) begin
        ratio_q[v] <= ratio_d[v];
        pos_q[v]   <= pos_d[v];
      end
      pol_q     <= pol_d;
      changed_q <= changed_d;
    end
  end

  // The result includes this hit's own change.
  assign result_o.now_enabled    = now_en;
  assign result_o.changed_so_far = changed_q | (now_en != hit_i.was_enabled);

endmodule
